>>> hw/rtl/lir_pkg.sv
// shared types and constants of the linear interpolation resampler
// transaction payload structs, register indexes and reset values
// no dependencies
package lir_pkg;

    // sample and register widths fixed by the stream format
    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int STEP_W        = 20;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = STEP_W;
    localparam int MAX_RESULTS   = 64;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_RATIO  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEREO_MODE = 2'd1;

    // register reset values
    localparam logic [STEP_W-1:0] STEP_RESET   = 20'd65536;
    localparam logic              STEREO_RESET = 1'b1;

    // input frame
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] in_left;
        logic signed [SAMPLE_WIDTH-1:0] in_right;
    } frame_t;

    // interpolated output frame
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_left;
        logic signed [SAMPLE_WIDTH-1:0] out_right;
        logic                           last_of_run;
    } result_t;

endpackage

>>> hw/rtl/lir_lerp_unit.sv
// shared interpolation unit: one registered multiplier and a final add
// result = base + floor((target - base) * frac / 2^FRAC_BITS)
// depends on lir_pkg
module lir_lerp_unit #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [lir_pkg::SAMPLE_WIDTH-1:0] base,
    input  logic signed [lir_pkg::SAMPLE_WIDTH-1:0] target,
    input  logic        [FRAC_BITS-1:0]         frac,
    output logic signed [lir_pkg::SAMPLE_WIDTH-1:0] result
);

    localparam int SW     = lir_pkg::SAMPLE_WIDTH;
    localparam int DIFF_W = SW + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SW-1:0]     base_reg;
    logic signed [PROD_W-1:0] shifted;

    // difference and product, sign extended
    assign diff = DIFF_W'(target) - DIFF_W'(base);
    assign prod = PROD_W'(diff) * $signed({1'b0, frac});

    // product register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod;
            base_reg <= base;
        end
    end

    // arithmetic shift gives floor; the sum stays in range so low bits suffice
    assign shifted = prod_reg >>> FRAC_BITS;
    assign result  = base_reg + shifted[SW-1:0];

endmodule

>>> hw/rtl/linear_interp_resampler_core.sv
// linear interpolation resampler: one frame in, zero to 64 frames out.
// a frame goes to check, left, right and result before the output register loads.
// no new frame is taken until the sequencer is idle; the single multiplier is shared
// by both channels under the sequencer, and a stalled output holds the result state.
// reset: position 1.0, previous frame zero, step 1.0, stereo on; no clearing pass.
// depends on lir_pkg and lir_lerp_unit
module linear_interp_resampler_core #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                frame_valid,
    output logic                                frame_stall,
    input  lir_pkg::frame_t                     frame,
    output logic                                result_valid,
    input  logic                                result_stall,
    output lir_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [lir_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW    = lir_pkg::SAMPLE_WIDTH;
    localparam int POS_W = ((FRAC_BITS > lir_pkg::STEP_W) ? FRAC_BITS : lir_pkg::STEP_W) + 1;
    localparam int CNT_W = $clog2(lir_pkg::MAX_RESULTS + 1);
    localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(lir_pkg::MAX_RESULTS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lir_pkg::MAX_RESULTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LEFT,
        S_RIGHT,
        S_RES
    } state_t;

    state_t                     state_reg, state_next;
    logic [lir_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       stereo_reg, stereo_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [SW-1:0]       prev_l_reg, prev_l_next;
    logic signed [SW-1:0]       prev_r_reg, prev_r_next;
    lir_pkg::frame_t            cur_reg, cur_next;
    logic                       res_valid_reg, res_valid_next;
    lir_pkg::result_t           res_reg, res_next;
    logic signed [SW-1:0]       left_reg, left_next;

    logic [POS_W-1:0]     pos_sum;
    logic                 pos_below_one;
    logic                 lerp_load;
    logic                 sel_right;
    logic signed [SW-1:0] lerp_base;
    logic signed [SW-1:0] lerp_target;
    logic signed [SW-1:0] lerp_result;
    logic                 cfg_hit;

    // shared multiplier, left then right
    assign lerp_load   = (state_reg == S_LEFT) || (state_reg == S_RIGHT);
    assign sel_right   = (state_reg == S_RIGHT);
    assign lerp_base   = sel_right ? prev_r_reg : prev_l_reg;
    assign lerp_target = sel_right ? cur_reg.in_right : cur_reg.in_left;

    lir_lerp_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_lerp (
        .clk    (clk),
        .load   (lerp_load),
        .base   (lerp_base),
        .target (lerp_target),
        .frac   (pos_reg[FRAC_BITS-1:0]),
        .result (lerp_result)
    );

    // position arithmetic
    assign pos_sum       = pos_reg + POS_W'(step_reg);
    assign pos_below_one = (pos_reg < ONE_POS);
    assign cfg_hit       = cfg_we && ((cfg_index == lir_pkg::CFG_STEP_RATIO) ||
                                      (cfg_index == lir_pkg::CFG_STEREO_MODE));

    // handshake outputs
    assign frame_stall  = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        stereo_next    = stereo_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        cur_next       = cur_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        left_next      = left_reg;

        // output transaction taken
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    cur_next   = frame;
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (pos_below_one && (cnt_reg < CNT_MAX))
                begin
                    state_next = S_LEFT;
                end
                else
                begin
                    // capped run drops the rest: position forced to 1.0 then minus 1.0
                    pos_next    = pos_below_one ? '0 : (pos_reg - ONE_POS);
                    prev_l_next = cur_reg.in_left;
                    prev_r_next = cur_reg.in_right;
                    state_next  = S_IDLE;
                end
            end
            S_LEFT:
            begin
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                left_next  = lerp_result;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next       = 1'b1;
                    res_next.out_left    = left_reg;
                    res_next.out_right   = stereo_reg ? lerp_result : '0;
                    res_next.last_of_run = (pos_sum >= ONE_POS) || (cnt_reg == CNT_LAST);
                    pos_next             = pos_sum;
                    cnt_next             = cnt_reg + CNT_W'(1);
                    state_next           = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts the stream
        if (cfg_hit)
        begin
            if (cfg_index == lir_pkg::CFG_STEP_RATIO)
            begin
                step_next = cfg_data;
            end
            else
            begin
                stereo_next = cfg_data[0];
            end
            pos_next    = ONE_POS;
            prev_l_next = '0;
            prev_r_next = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= lir_pkg::STEP_RESET;
            stereo_reg    <= lir_pkg::STEREO_RESET;
            pos_reg       <= ONE_POS;
            cnt_reg       <= '0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            cur_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            stereo_reg    <= stereo_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            prev_l_reg    <= prev_l_next;
            prev_r_reg    <= prev_r_next;
            cur_reg       <= cur_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            left_reg      <= left_next;
        end
    end

    // run length never exceeds the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
    else $error("result count beyond cap");

    // interpolation only starts with a position below 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEFT) |-> (pos_reg < ONE_POS))
    else $error("interpolation started at position 1.0 or more");

    // a new result is loaded only in the result step, which then returns to the check
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_RES) && (state_reg == S_CHECK))
    else $error("result loaded outside the result step");

    // mono output carries no right channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !stereo_reg) |-> (res_reg.out_right == '0))
    else $error("right channel nonzero in mono mode");

endmodule

>>> verif/linear_interp_resampler_checker.sv
// result checker for the linear interpolation resampler core
// watches the frame, result and register ports, predicts output frames, compares them
// depends on lir_pkg
`timescale 1ns / 1ps

module linear_interp_resampler_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            frame_valid,
    input  logic                            frame_stall,
    input  lir_pkg::frame_t                 frame,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  lir_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [lir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              pending
);

    localparam int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH;
    localparam int STEP_W       = lir_pkg::STEP_W;
    localparam int FRAC_BITS    = lir_pkg::FRAC_BITS_DEF;

    localparam logic [20:0] POS_ONE = 21'd1 << FRAC_BITS;

    // shadow copy of the registers and the stream state
    logic [STEP_W-1:0]              step_q416;
    logic                           stereo_on;
    logic [20:0]                    position;
    logic signed [SAMPLE_WIDTH-1:0] hist_left;
    logic signed [SAMPLE_WIDTH-1:0] hist_right;

    lir_pkg::result_t pending_outputs[$];
    int               fail_total;

    // a + floor((b - a) * frac / 2^FRAC_BITS)
    function automatic logic signed [SAMPLE_WIDTH-1:0] interp_sample(
        input logic signed [SAMPLE_WIDTH-1:0] a,
        input logic signed [SAMPLE_WIDTH-1:0] b,
        input logic [20:0]                    frac
    );
        longint span;
        longint prod;
        longint sum;
        span = longint'(b) - longint'(a);
        prod = span * longint'(frac);
        sum  = longint'(a) + (prod >>> FRAC_BITS);
        return sum[SAMPLE_WIDTH-1:0];
    endfunction

    task automatic clear_stream();
        position   = POS_ONE;
        hist_left  = '0;
        hist_right = '0;
    endtask

    // queue every output frame that one input frame causes
    task automatic predict_frame(input lir_pkg::frame_t f);
        int               count;
        logic [20:0]      next_pos;
        lir_pkg::result_t r;
        count = 0;
        while (position < POS_ONE && count < lir_pkg::MAX_RESULTS)
        begin
            next_pos      = position + step_q416;
            r.out_left    = interp_sample(hist_left, f.in_left, position);
            r.out_right   = stereo_on ? interp_sample(hist_right, f.in_right, position) : '0;
            r.last_of_run = (next_pos >= POS_ONE) || (count == lir_pkg::MAX_RESULTS - 1);
            pending_outputs.push_back(r);
            position = next_pos;
            count++;
        end
        // run cut short at the cap drops the rest of the span
        if (position < POS_ONE)
            position = POS_ONE;
        position   = position - POS_ONE;
        hist_left  = f.in_left;
        hist_right = f.in_right;
    endtask

    task automatic check_result(input lir_pkg::result_t got);
        lir_pkg::result_t want;
        if (pending_outputs.size() == 0)
        begin
            fail_total++;
            if (fail_total <= 10)
                $display("unexpected result transaction: L=%0d R=%0d last=%0b",
                         got.out_left, got.out_right, got.last_of_run);
        end
        else
        begin
            want = pending_outputs.pop_front();
            if (got.out_left !== want.out_left || got.out_right !== want.out_right
                    || got.last_of_run !== want.last_of_run)
            begin
                fail_total++;
                if (fail_total <= 10)
                    $display({"result mismatch: expected L=%0d R=%0d last=%0b,",
                              " got L=%0d R=%0d last=%0b"},
                             want.out_left, want.out_right, want.last_of_run,
                             got.out_left, got.out_right, got.last_of_run);
            end
        end
    endtask

    // register writes, result compare, then prediction for an accepted frame
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_q416 = lir_pkg::STEP_RESET;
            stereo_on = lir_pkg::STEREO_RESET;
            clear_stream();
            pending_outputs.delete();
            fail_total = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lir_pkg::CFG_STEP_RATIO:
                    begin
                        step_q416 = cfg_data[STEP_W-1:0];
                        clear_stream();
                    end
                    lir_pkg::CFG_STEREO_MODE:
                    begin
                        stereo_on = cfg_data[0];
                        clear_stream();
                    end
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
                check_result(result);
            if (frame_valid && !frame_stall)
                predict_frame(frame);
            mismatches <= fail_total;
            pending    <= pending_outputs.size();
        end
    end

endmodule

>>> verif/linear_interp_resampler_core_test.sv
// testbench top for the linear interpolation resampler core
// drives frames, register writes and result stalls; the checker predicts and compares
// depends on lir_pkg, linear_interp_resampler_core and linear_interp_resampler_checker
`timescale 1ns / 1ps

module linear_interp_resampler_core_test;

    localparam int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH;
    localparam int STEP_W       = lir_pkg::STEP_W;
    localparam int CFG_INDEX_W  = lir_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W   = lir_pkg::CFG_DATA_W;

    // slowest run: every frame yielding 64 results, taken several times over
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_FRAMES = 290;

    // register indexes past the end of the list
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = 16'sh8000;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   frame_valid  = 1'b0;
    logic                   frame_stall;
    lir_pkg::frame_t        frame        = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    lir_pkg::result_t       result;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    int mismatches;
    int outputs_pending;
    int cycle_count = 0;
    int stall_run   = 0;
    int stall_mode  = 0;

    linear_interp_resampler_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    linear_interp_resampler_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (outputs_pending)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall pattern: quiet runs, random runs, solid stall runs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run  = (stall_mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 60);
            end
            stall_run--;
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= 1'($urandom_range(0, 1));
                2:       result_stall <= 1'b1;
                default: result_stall <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic lir_pkg::frame_t make_frame(input logic signed [SAMPLE_WIDTH-1:0] l,
                                                   input logic signed [SAMPLE_WIDTH-1:0] r);
        lir_pkg::frame_t f;
        f.in_left  = l;
        f.in_right = r;
        return f;
    endfunction

    // mostly full-range samples, with the extremes and zero crossings mixed in
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return -16'sd1;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // hold the frame until the transaction completes
    task automatic put_frame(input lir_pkg::frame_t f);
        frame_valid <= 1'b1;
        frame       <= f;
        do @(posedge clk); while (frame_stall);
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic drain();
        frame_valid <= 1'b0;
        do @(posedge clk); while (outputs_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one write per edge, write enable left high for back-to-back writes
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic configure(input logic [STEP_W-1:0] step, input logic stereo);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = {(CFG_DATA_W-1)'($urandom), stereo};
        drain();
        if ($urandom_range(0, 1))
        begin
            write_reg(lir_pkg::CFG_STEP_RATIO, step);
            write_reg(lir_pkg::CFG_STEREO_MODE, mode_word);
        end
        else
        begin
            write_reg(lir_pkg::CFG_STEREO_MODE, mode_word);
            write_reg(lir_pkg::CFG_STEP_RATIO, step);
        end
        cfg_we <= 1'b0;
    endtask

    // random frames in bursts with random gaps, now and then a full drain
    task automatic send_stream(input int count);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
                if (gap != 0)
                begin
                    frame_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            if ($urandom_range(0, 39) == 0)
                drain();
            put_frame(make_frame(pick_sample(), pick_sample()));
            burst_left--;
        end
    endtask

    // stimulus
    initial
    begin
        int                sent;
        int                count;
        logic [STEP_W-1:0] step;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unity step, stereo, full-scale swings
        put_frame(make_frame(S_MAX, S_MIN));
        put_frame(make_frame(S_MIN, S_MAX));
        put_frame(make_frame(16'sd0, -16'sd1));
        put_frame(make_frame(-16'sd1, 16'sd0));

        // fractional step across full-scale swings
        configure(20'h0C000, 1'b1);
        put_frame(make_frame(S_MAX, S_MIN));
        put_frame(make_frame(S_MIN, S_MAX));
        put_frame(make_frame(S_MAX, S_MIN));
        put_frame(make_frame(16'sd1, -16'sd1));

        // mono: right channel still tracked but output as zero
        configure(20'h0C000, 1'b0);
        put_frame(make_frame(S_MIN, S_MAX));
        put_frame(make_frame(S_MAX, S_MIN));
        put_frame(make_frame(16'sd12345, -16'sd12345));

        // zero step: every frame after the first hits the result cap
        configure(20'd0, 1'b1);
        put_frame(make_frame(S_MAX, S_MIN));
        put_frame(make_frame(S_MIN, S_MAX));
        put_frame(make_frame(16'sd100, -16'sd100));

        // step just below range: cap reached before the span ends
        configure(20'd1000, 1'b1);
        put_frame(make_frame(S_MIN, S_MAX));
        put_frame(make_frame(S_MAX, S_MIN));

        // smallest step in range: exactly a full run per frame after the first
        configure(20'd1024, 1'b0);
        put_frame(make_frame(S_MIN, S_MAX));
        put_frame(make_frame(S_MAX, S_MIN));

        // largest step: most frames produce nothing
        configure(20'hFFFFF, 1'b1);
        put_frame(make_frame(S_MAX, S_MIN));
        put_frame(make_frame(S_MIN, S_MAX));
        put_frame(make_frame(16'sd7, -16'sd7));
        put_frame(make_frame(S_MIN, S_MIN));

        // writes past the register list must leave the stream untouched
        drain();
        write_reg(CFG_SPARE_2, 20'hFFFFF);
        write_reg(CFG_SPARE_3, 20'h00000);
        cfg_we <= 1'b0;
        put_frame(make_frame(S_MAX, S_MAX));
        put_frame(make_frame(S_MIN, S_MIN));

        // random phases, each with its own settings
        sent = 0;
        while (sent < RANDOM_FRAMES)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    step  = STEP_W'($urandom_range(1024, 4096));
                    count = $urandom_range(4, 10);
                end
                1:
                begin
                    step  = STEP_W'($urandom_range(0, 1023));
                    count = $urandom_range(2, 4);
                end
                2:
                begin
                    step  = STEP_W'($urandom_range(65537, 1048575));
                    count = $urandom_range(20, 50);
                end
                3:
                begin
                    step  = 20'd65536;
                    count = $urandom_range(10, 30);
                end
                default:
                begin
                    step  = STEP_W'($urandom_range(8192, 65535));
                    count = $urandom_range(15, 40);
                end
            endcase
            configure(step, 1'($urandom_range(0, 1)));
            send_stream(count);
            sent += count;
        end

        drain();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> linear_interp_resampler_core.f
hw/rtl/lir_pkg.sv
hw/rtl/lir_lerp_unit.sv
hw/rtl/linear_interp_resampler_core.sv
verif/linear_interp_resampler_checker.sv
verif/linear_interp_resampler_core_test.sv
